// ===== src/mm2_pkg.sv =====
// Shared constants, types and helpers for the MurmurHash2 64A hash unit.
package mm2_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT  = 47;

    localparam int unsigned ADDR_W        = 4;
    localparam logic [ADDR_W-1:0] CFG_ADDR_SEED = 4'h0;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mm2_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mm2_mul_rsp_t;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        xorshift = v ^ (v >> MIX_SHIFT);
    endfunction

    function automatic logic [63:0] tail_mask(input logic [3:0] nbytes);
        logic [6:0] bits;
        bits = {nbytes[2:0], 3'b000} + 7'd0;
        tail_mask = (64'h1 << bits) - 64'h1;
    endfunction

endpackage

// ===== src/mm2_mul.sv =====
// Shared multiply-by-constant unit: 64-bit product mod 2^64 from one 32x32 multiplier.
module mm2_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mm2_pkg::mm2_mul_req_t req,
    output mm2_pkg::mm2_mul_rsp_t rsp
);
    import mm2_pkg::*;

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] op_reg, op_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin mul_a = op_reg[31:0];  mul_b = MIX_MUL_LO; end
            2'd1:    begin mul_a = op_reg[63:32]; mul_b = MIX_MUL_LO; end
            2'd2:    begin mul_a = op_reg[31:0];  mul_b = MIX_MUL_HI; end
            default: begin mul_a = 32'd0;         mul_b = 32'd0;      end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd0:    acc_next = acc_reg;
                2'd1:    acc_next = prod_reg;
                2'd2:    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                default:
                begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'd0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            op_next   = req.operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg || done_reg)
        else $error("multiplier started while busy");

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == 2'd3) |=> done_reg && !busy_reg)
        else $error("multiplier did not finish after last step");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

// ===== src/murmur2_64bit_hash_unit.sv =====
// Top level: MurmurHash2 64A streaming hash unit with sequencer and APB seed register.
// Computes the 64-bit MurmurHash2 (64A) of a message fed as little-endian 8-byte chunks;
// the first chunk's message_length starts the hash, the chunk marked last closes it and
// produces one hash_value. Every 64-bit multiply runs on one shared 32x32 multiplier in
// four steps. A middle chunk takes three multiplies, the first chunk of a message one more
// (length multiply), and a full last chunk one more for the avalanche, plus the output
// step; a partial last chunk takes two multiplies (tail and avalanche), an empty one only
// the avalanche. in_ready is high only while the sequencer is idle; a finished hash
// waits in the output register and does not block input.
module murmur2_64bit_hash_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mm2_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [63:0]                chunk,
    input  logic [3:0]                 valid_bytes,
    input  logic                       last,
    input  logic [30:0]                message_length,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [63:0]                hash_value
);
    import mm2_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LEN   = 9'b000000010,
        S_ROUTE = 9'b000000100,
        S_K1    = 9'b000001000,
        S_K2    = 9'b000010000,
        S_BH    = 9'b000100000,
        S_HT    = 9'b001000000,
        S_AV    = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t       state_reg, state_next;
    logic         open_reg, open_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  hash_reg, hash_next;
    logic [63:0]  seed_reg, seed_next;
    logic [63:0]  h_reg, h_next;
    logic [63:0]  chunk_reg, chunk_next;
    logic [3:0]   vb_reg, vb_next;
    logic         last_reg, last_next;
    logic         in_fire;
    logic         cfg_write;
    logic         out_free;
    mm2_mul_req_t mul_req;
    mm2_mul_rsp_t mul_rsp;

    mm2_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == CFG_ADDR_SEED) ? seed_reg : 64'd0;
    assign seed_next = (cfg_write && paddr == CFG_ADDR_SEED) ? pwdata : seed_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hash_next      = hash_reg;
        h_next         = h_reg;
        chunk_next     = chunk_reg;
        vb_next        = vb_reg;
        last_next      = last_reg;
        mul_req.start   = 1'b0;
        mul_req.operand = 64'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    chunk_next = chunk;
                    vb_next    = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
                    last_next  = last;
                    if (!open_reg)
                    begin
                        open_next       = 1'b1;
                        mul_req.start   = 1'b1;
                        mul_req.operand = {33'd0, message_length};
                        state_next      = S_LEN;
                    end
                    else
                    begin
                        state_next = S_ROUTE;
                    end
                end
            end
            S_LEN:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = seed_reg ^ mul_rsp.result;
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                mul_req.start = 1'b1;
                if (!last_reg || vb_reg == FULL_BYTES)
                begin
                    mul_req.operand = chunk_reg;
                    state_next      = S_K1;
                end
                else if (vb_reg != 4'd0)
                begin
                    mul_req.operand = h_reg ^ (chunk_reg & tail_mask(vb_reg));
                    state_next      = S_HT;
                end
                else
                begin
                    mul_req.operand = xorshift(h_reg);
                    state_next      = S_AV;
                end
            end
            S_K1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = xorshift(mul_rsp.result);
                    state_next      = S_K2;
                end
            end
            S_K2:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ mul_rsp.result;
                    state_next      = S_BH;
                end
            end
            S_BH:
            begin
                if (mul_rsp.done)
                begin
                    h_next = mul_rsp.result;
                    if (last_reg)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = xorshift(mul_rsp.result);
                        state_next      = S_AV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_HT:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = xorshift(mul_rsp.result);
                    state_next      = S_AV;
                end
            end
            S_AV:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = mul_rsp.result;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    h_next         = xorshift(h_reg);
                    hash_next      = xorshift(h_reg);
                    out_valid_next = 1'b1;
                    open_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= 64'd0;
            h_reg         <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg  <= hash_next;
        chunk_reg <= chunk_next;
        vb_reg    <= vb_next;
        last_reg  <= last_next;
    end

    a_first_chunk_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !open_reg) |=> state_reg == S_LEN && open_reg)
        else $error("first chunk did not start length multiply");

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_LEN || state_reg == S_K1 || state_reg == S_K2 ||
                          state_reg == S_BH || state_reg == S_HT || state_reg == S_AV))
        else $error("multiplier result arrived with no one waiting");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> out_valid_reg && !open_reg && state_reg == S_IDLE)
        else $error("finished hash not loaded into output register");

    a_fin_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> last_reg)
        else $error("finish reached on a non-last chunk");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the MurmurHash2 64A streaming hash unit.
`timescale 1ns / 100ps

module tb;
    import mm2_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WAIT   = 60;
    localparam int PHASE_REQS  = 134;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        fin;
        logic [30:0] total;
        bit          drain;
    } req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [63:0]         pwdata = '0;
    logic [63:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [63:0]         chunk = '0;
    logic [3:0]          valid_bytes = '0;
    logic                last = 1'b0;
    logic [30:0]         message_length = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [63:0]         hash_value;

    req_t        req_q[$];
    logic [63:0] hash_q[$];
    req_t        cur;
    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    logic [63:0] seed_shadow = '0;
    logic [63:0] acc_hash = '0;
    logic        in_message = 1'b0;
    bit          no_idle = 1'b0;
    int          reqs_queued = 0;
    int          reqs_taken = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    int          rx_hold = 0;
    int          results_seen = 0;
    int          err_count = 0;
    int          cycle_cnt = 0;

    murmur2_64bit_hash_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chunk          (chunk),
        .valid_bytes    (valid_bytes),
        .last           (last),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] fold_block(input logic [63:0] h, input logic [63:0] k);
        logic [63:0] kk;
        kk = k * MIX_MUL;
        kk = kk ^ (kk >> MIX_SHIFT);
        kk = kk * MIX_MUL;
        fold_block = (h ^ kk) * MIX_MUL;
    endfunction

    task automatic absorb_request(input logic [63:0] data, input logic [3:0] nbytes,
                                  input logic fin, input logic [30:0] total);
        logic [63:0] h;
        logic [3:0]  n;
        if (!in_message) begin
            acc_hash   = seed_shadow ^ ({33'd0, total} * MIX_MUL);
            in_message = 1'b1;
        end
        h = acc_hash;
        if (!fin) begin
            acc_hash = fold_block(h, data);
        end
        else begin
            n = (nbytes > FULL_BYTES) ? FULL_BYTES : nbytes;
            if (n == FULL_BYTES)
                h = fold_block(h, data);
            else if (n != 4'd0)
                h = (h ^ (data & ~(64'hFFFF_FFFF_FFFF_FFFF << {n[2:0], 3'b000}))) * MIX_MUL;
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_MUL;
            h = h ^ (h >> MIX_SHIFT);
            hash_q.push_back(h);
            acc_hash   = h;
            in_message = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // monitor: config shadow, request prediction, hash check
    always @(posedge clk) begin
        logic [63:0] want;
        in_fire  <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n) begin
            if (psel && penable && pwrite && pready && paddr == CFG_ADDR_SEED)
                seed_shadow = pwdata;
            if (in_valid && in_ready) begin
                absorb_request(chunk, valid_bytes, last, message_length);
                reqs_taken++;
            end
            if (out_valid && out_ready) begin
                if (hash_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash %h", hash_value));
                end
                else begin
                    want = hash_q.pop_front();
                    if (hash_value !== want)
                        report_mismatch($sformatf("hash got %h want %h", hash_value, want));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() != 0 && !(req_q[0].drain && hash_q.size() != 0)) begin
                cur = req_q.pop_front();
                chunk          <= cur.data;
                valid_bytes    <= cur.nbytes;
                last           <= cur.fin;
                message_length <= cur.total;
                in_valid       <= 1'b1;
                tx_gap = draw_wait();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // hash receiver; long hold-offs back the unit up
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_fire) begin
                results_seen++;
                rx_stall = draw_wait();
                if (results_seen == 30 || results_seen == 150)
                    rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_stall > 0) begin
                if (out_valid)
                    rx_stall--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_req(input logic [63:0] data, input logic [3:0] nbytes,
                            input logic fin, input logic [30:0] total, input bit drain);
        req_t r;
        r.data   = data;
        r.nbytes = nbytes;
        r.fin    = fin;
        r.total  = total;
        r.drain  = drain;
        req_q.push_back(r);
        reqs_queued++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sloppy messages carry short middle chunks and oversized counts
    task automatic queue_message(input int nbytes, input logic [30:0] total,
                                 input bit drain, input bit sloppy);
        int          n_chunks;
        int          rem;
        logic [3:0]  nb;
        logic [30:0] len;
        rem      = nbytes % 8;
        n_chunks = (rem == 0 && nbytes > 0) ? nbytes / 8 : nbytes / 8 + 1;
        for (int i = 0; i < n_chunks; i++) begin
            if (i != n_chunks - 1)
                nb = sloppy ? 4'($urandom_range(0, 15)) : FULL_BYTES;
            else if (rem == 0 && nbytes > 0)
                nb = sloppy ? 4'($urandom_range(8, 15)) : FULL_BYTES;
            else
                nb = 4'(rem);
            len = (i == 0) ? total : 31'($urandom);
            push_req(rand64(), nb, i == n_chunks - 1, len, drain && i == 0);
        end
    endtask

    task automatic settle();
        while (reqs_taken != reqs_queued || hash_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = CFG_ADDR_SEED;
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        logic [63:0] seeds[6];
        int          phase_reqs;
        int          nbytes;
        int          pick;
        logic [30:0] total;

        seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[1] = rand64();
        seeds[2] = 64'd1;
        seeds[3] = 64'h8000_0000_0000_0000;
        seeds[4] = rand64();
        seeds[5] = 64'd0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        write_seed(64'd0);

        // directed: empty, full, every tail size, saturated counts, short middles,
        // length mismatch, maximum length
        push_req(rand64(), 4'd0, 1'b1, 31'd0, 1'b0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, FULL_BYTES, 1'b1, 31'd8, 1'b0);
        push_req(64'd0, FULL_BYTES, 1'b1, 31'd8, 1'b0);
        for (int k = 1; k < 8; k++)
            push_req(rand64(), 4'(k), 1'b1, 31'(k), 1'b0);
        push_req(rand64(), 4'd15, 1'b1, 31'h7FFF_FFFF, 1'b0);
        push_req(rand64(), 4'd9, 1'b1, 31'd0, 1'b0);
        push_req(rand64(), 4'd0, 1'b0, 31'd16, 1'b0);
        push_req(rand64(), 4'd3, 1'b0, 31'd0, 1'b0);
        push_req(64'd0, 4'd5, 1'b1, 31'h7FFF_FFFF, 1'b0);
        push_req(rand64(), FULL_BYTES, 1'b0, 31'd1000, 1'b1);
        push_req(rand64(), FULL_BYTES, 1'b1, 31'd0, 1'b0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 31'h7FFF_FFFF, 1'b0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, FULL_BYTES, 1'b0, 31'd20, 1'b0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, FULL_BYTES, 1'b0, 31'd0, 1'b0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1, 31'd0, 1'b0);
        settle();

        for (int p = 0; p < 6; p++) begin
            no_idle = (p == 1 || p == 4);
            write_seed(seeds[p]);
            phase_reqs = reqs_queued;
            while (reqs_queued - phase_reqs < PHASE_REQS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    nbytes = $urandom_range(0, 24);
                else if (pick < 9)
                    nbytes = $urandom_range(25, 64);
                else
                    nbytes = $urandom_range(65, 300);
                total = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'(nbytes);
                queue_message(nbytes, total,
                              reqs_queued == phase_reqs || $urandom_range(0, 19) == 0,
                              $urandom_range(0, 5) == 0);
            end
            settle();
        end

        if (err_count == 0 && hash_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
